// ===== rtl/core/mdioms_pkg.sv =====
`timescale 1ns / 1ps

package mdioms_pkg;

  typedef enum logic [2:0] {
    PH_PREAMBLE    = 3'd0,
    PH_FRAME_START = 3'd1,
    PH_HEADER      = 3'd2,
    PH_WRITE       = 3'd3,
    PH_READ_TA     = 3'd4,
    PH_READ_ZERO   = 3'd5,
    PH_READ_DATA   = 3'd6
  } phase_t;

  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned SHIFT_W     = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned HEADER_BITS = 2 + 2 + 5 + 5;
  localparam int unsigned WRITE_BITS  = 16 + 2;

  localparam logic [1:0] START_FIELD = 2'b01;
  localparam logic [1:0] READ_OP     = 2'd2;
  localparam logic [1:0] OP_WRITE    = 2'd1;

  localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 5'd0;
  localparam logic [ADDR_W-1:0] STATUS_REG     = 5'd1;
  localparam logic [ADDR_W-1:0] PHY_ADDR_RESET = 5'd0;
  localparam logic [DATA_W-1:0] STATUS_RESET   = 16'h0004;

  localparam logic CFG_PHY_ADDRESS  = 1'b0;
  localparam logic CFG_STATUS_VALUE = 1'b1;

  typedef struct packed {
    logic              drive_enable;
    logic              drive_value;
    logic              write_valid;
    logic [ADDR_W-1:0] write_register;
    logic [DATA_W-1:0] write_value;
  } result_t;

endpackage

// ===== rtl/core/mdioms_frame.sv =====
`timescale 1ns / 1ps

module mdioms_frame (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                clock_edge,
  input  logic                                mdio_in,
  input  logic [mdioms_pkg::ADDR_W-1:0]       phy_address,
  input  logic [mdioms_pkg::DATA_W-1:0]       status_value,
  output mdioms_pkg::result_t                 result
);

  logic [mdioms_pkg::SHIFT_W-1:0] shift_bits, shift_bits_next;
  logic [mdioms_pkg::COUNT_W-1:0] bit_count, bit_count_next;
  logic [mdioms_pkg::ADDR_W-1:0]  register_number, register_number_next;
  mdioms_pkg::phase_t             phase, phase_next;
  logic                           driving, driving_next;
  logic                           line_out, line_out_next;

  logic [mdioms_pkg::SHIFT_W-1:0] shifted;
  logic [mdioms_pkg::COUNT_W-1:0] count_inc;
  logic [mdioms_pkg::DATA_W-1:0]  read_value;

  assign shifted    = {shift_bits[mdioms_pkg::SHIFT_W-2:0], mdio_in};
  assign count_inc  = bit_count + 5'd1;
  assign read_value = (register_number == mdioms_pkg::STATUS_REG) ? status_value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits      <= '0;
      bit_count       <= '0;
      register_number <= '0;
      phase           <= mdioms_pkg::PH_PREAMBLE;
      driving         <= 1'b0;
      line_out        <= 1'b0;
    end else if (step) begin
      shift_bits      <= shift_bits_next;
      bit_count       <= bit_count_next;
      register_number <= register_number_next;
      phase           <= phase_next;
      driving         <= driving_next;
      line_out        <= line_out_next;
    end
  end

  always_comb begin
    shift_bits_next      = shift_bits;
    bit_count_next       = bit_count;
    register_number_next = register_number;
    phase_next           = phase;
    driving_next         = driving;
    line_out_next        = line_out;
    result               = '0;

    if (clock_edge) begin
      unique case (phase)
        mdioms_pkg::PH_READ_ZERO, mdioms_pkg::PH_READ_DATA: begin
        end
        mdioms_pkg::PH_PREAMBLE: begin
          shift_bits_next = shifted;
          if (shifted == '1) begin
            phase_next = mdioms_pkg::PH_FRAME_START;
          end
        end
        mdioms_pkg::PH_FRAME_START: begin
          shift_bits_next = shifted;
          if (!mdio_in) begin
            bit_count_next = 5'd1;
            phase_next     = mdioms_pkg::PH_HEADER;
          end
        end
        mdioms_pkg::PH_HEADER: begin
          shift_bits_next = shifted;
          bit_count_next  = count_inc;
          if (count_inc == 5'(mdioms_pkg::HEADER_BITS)) begin
            register_number_next = shifted[4:0];
            priority if (shifted[13:12] != mdioms_pkg::START_FIELD ||
                         (shifted[9:5] != mdioms_pkg::BROADCAST_ADDR &&
                          shifted[9:5] != phy_address)) begin
              phase_next = mdioms_pkg::PH_PREAMBLE;
            end else if (shifted[11:10] == mdioms_pkg::OP_WRITE) begin
              bit_count_next = '0;
              phase_next     = mdioms_pkg::PH_WRITE;
            end else if (shifted[11:10] == mdioms_pkg::READ_OP) begin
              phase_next = mdioms_pkg::PH_READ_TA;
            end else begin
              phase_next = mdioms_pkg::PH_PREAMBLE;
            end
          end
        end
        mdioms_pkg::PH_WRITE: begin
          shift_bits_next = shifted;
          bit_count_next  = count_inc;
          if (count_inc == 5'(mdioms_pkg::WRITE_BITS)) begin
            result.write_valid    = 1'b1;
            result.write_register = register_number;
            result.write_value    = shifted[mdioms_pkg::DATA_W-1:0];
            phase_next            = mdioms_pkg::PH_PREAMBLE;
          end
        end
        mdioms_pkg::PH_READ_TA: begin
          shift_bits_next = shifted;
          phase_next      = mdioms_pkg::PH_READ_ZERO;
        end
        default: begin
          shift_bits_next = shifted;
          phase_next      = mdioms_pkg::PH_PREAMBLE;
        end
      endcase
    end else begin
      unique case (phase)
        mdioms_pkg::PH_READ_ZERO: begin
          driving_next    = 1'b1;
          line_out_next   = 1'b0;
          shift_bits_next = {16'd0, read_value};
          bit_count_next  = '0;
          phase_next      = mdioms_pkg::PH_READ_DATA;
        end
        mdioms_pkg::PH_READ_DATA: begin
          if (bit_count >= 5'(mdioms_pkg::DATA_W)) begin
            driving_next    = 1'b0;
            line_out_next   = 1'b0;
            shift_bits_next = '0;
            bit_count_next  = '0;
            phase_next      = mdioms_pkg::PH_PREAMBLE;
          end else begin
            line_out_next   = shift_bits[mdioms_pkg::DATA_W-1];
            shift_bits_next = {16'd0, shift_bits[mdioms_pkg::DATA_W-2:0], 1'b0};
            bit_count_next  = count_inc;
          end
        end
        default: begin
        end
      endcase
    end

    result.drive_enable = driving_next;
    result.drive_value  = driving_next & line_out_next;
  end

  // drive window matches the data phase exactly
  assert property (@(posedge clk) disable iff (rst)
    driving == (phase == mdioms_pkg::PH_READ_DATA))
    else $error("drive flag out of step with read data phase");

  assert property (@(posedge clk) disable iff (rst)
    phase == mdioms_pkg::PH_READ_DATA |-> bit_count <= 5'(mdioms_pkg::DATA_W))
    else $error("read bit count overran");

  assert property (@(posedge clk) disable iff (rst)
    phase == mdioms_pkg::PH_HEADER |-> bit_count < 5'(mdioms_pkg::HEADER_BITS))
    else $error("header bit count overran");

  assert property (@(posedge clk) disable iff (rst)
    phase == mdioms_pkg::PH_WRITE |-> bit_count < 5'(mdioms_pkg::WRITE_BITS))
    else $error("write bit count overran");

endmodule

// ===== rtl/core/mdioms_out.sv =====
`timescale 1ns / 1ps

module mdioms_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mdioms_pkg::result_t result,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output mdioms_pkg::result_t held
);

  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held <= result;
    end
  end

endmodule

// ===== rtl/core/mdio_management_slave.sv =====
`timescale 1ns / 1ps
// mdio clause 22 management slave, phy side, one mdc edge per item
// result path: each accepted item passes the input register, then the result register
// throughput: one item per cycle, sustained while out_stall stays low
// reset: synchronous rst returns the frame decoder to preamble wait, clears
// the shift register and drive state, and loads phy_address 0, status_value 4

module mdio_management_slave (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          clock_edge,
  input  logic                          mdio_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          drive_enable,
  output logic                          drive_value,
  output logic                          write_valid,
  output logic [mdioms_pkg::ADDR_W-1:0] write_register,
  output logic [mdioms_pkg::DATA_W-1:0] write_value,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [mdioms_pkg::DATA_W-1:0] cfg_data
);

  logic [mdioms_pkg::ADDR_W-1:0] phy_address;
  logic [mdioms_pkg::DATA_W-1:0] status_value;

  logic in_full;
  logic in_edge;
  logic in_bit;
  logic take;
  logic step;

  mdioms_pkg::result_t result;
  mdioms_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      phy_address  <= mdioms_pkg::PHY_ADDR_RESET;
      status_value <= mdioms_pkg::STATUS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mdioms_pkg::CFG_PHY_ADDRESS:  phy_address  <= cfg_data[mdioms_pkg::ADDR_W-1:0];
        mdioms_pkg::CFG_STATUS_VALUE: status_value <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign step     = in_full && take;
  assign in_stall = in_full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_edge <= clock_edge;
      in_bit  <= mdio_in;
    end
  end

  mdioms_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .clock_edge   (in_edge),
    .mdio_in      (in_bit),
    .phy_address  (phy_address),
    .status_value (status_value),
    .result       (result)
  );

  mdioms_out u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .result    (result),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign drive_enable   = held.drive_enable;
  assign drive_value    = held.drive_value;
  assign write_valid    = held.write_valid;
  assign write_register = held.write_register;
  assign write_value    = held.write_value;

endmodule
